// ===== rtl/sbwrng_pkg.sv =====
// Shared types and constants for the subtract-with-borrow / Weyl random word generator.
// No dependencies; used by every other file of the block.

package sbwrng_pkg;

	localparam int WORD_W  = 32;
	localparam int KIND_W  = 2;
	localparam int INDEX_W = 6;

	localparam int LONG_LAG_DEF  = 43;
	localparam int SHORT_LAG_DEF = 22;

	// modulus 2^32-5, added back when the subtraction goes negative
	localparam logic [WORD_W-1:0] SWB_BASE  = 32'hFFFF_FFFB;
	localparam logic [WORD_W-1:0] WEYL_STEP = 32'd362436069;

	localparam logic [KIND_W-1:0] KIND_GEN  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LAG  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WEYL = 2'd2;

	// operation carried by the word in stage 1
	typedef struct packed {
		logic gen;
		logic restart;
		logic lag_wr;
	} op_t;

endpackage

// ===== rtl/sbwrng_lag_ram.sv =====
// Lag table: one write port, two registered read ports, per-entry valid bits
// (unwritten entries read as zero) and same-edge write-to-read forwarding.
// Depends on sbwrng_pkg.

module sbwrng_lag_ram #(
	parameter int DEPTH = sbwrng_pkg::LONG_LAG_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 raddr_a,
	input  logic [AW-1:0]                 raddr_b,
	output logic [sbwrng_pkg::WORD_W-1:0] rdata_a,
	output logic [sbwrng_pkg::WORD_W-1:0] rdata_b,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [sbwrng_pkg::WORD_W-1:0] wdata
);

	logic [sbwrng_pkg::WORD_W-1:0] mem [DEPTH];
	logic [sbwrng_pkg::WORD_W-1:0] rd_a_q, rd_b_q;
	logic [sbwrng_pkg::WORD_W-1:0] byp_data_a_q, byp_data_b_q;
	logic [DEPTH-1:0]              vld_q;
	logic                          vld_a_q, vld_b_q;
	logic                          byp_a_q, byp_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_a_q       <= mem[raddr_a];
			rd_b_q       <= mem[raddr_b];
			byp_data_a_q <= wdata;
			byp_data_b_q <= wdata;
		end
	end

	// a write on the read edge is missed by the array read; take it from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
			byp_a_q <= 1'b0;
			byp_b_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= vld_q[raddr_a];
				vld_b_q <= vld_q[raddr_b];
				byp_a_q <= we && (waddr == raddr_a);
				byp_b_q <= we && (waddr == raddr_b);
			end
		end
	end

	assign rdata_a = byp_a_q ? byp_data_a_q : (vld_a_q ? rd_a_q : '0);
	assign rdata_b = byp_b_q ? byp_data_b_q : (vld_b_q ? rd_b_q : '0);

endmodule

// ===== rtl/sbwrng_step.sv =====
// Generator step: subtract-with-borrow on the two lag words, borrow register,
// and the Weyl sequence held in negated, pre-stepped form. Depends on sbwrng_pkg.

module sbwrng_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  sbwrng_pkg::op_t               op,
	input  logic [sbwrng_pkg::WORD_W-1:0] seed,
	input  logic [sbwrng_pkg::WORD_W-1:0] short_word,
	input  logic [sbwrng_pkg::WORD_W-1:0] long_word,
	output logic [sbwrng_pkg::WORD_W-1:0] lag_word,
	output logic [sbwrng_pkg::WORD_W-1:0] out_word
);

	logic                          borrow_q;
	// holds WEYL_STEP - weyl, i.e. minus the Weyl word after the next step
	logic [sbwrng_pkg::WORD_W-1:0] weyl_neg_q;
	logic [sbwrng_pkg::WORD_W:0]   diff;
	logic                          neg;

	assign diff = {1'b0, short_word} - {1'b0, long_word}
	            - {{sbwrng_pkg::WORD_W{1'b0}}, borrow_q};
	assign neg  = diff[sbwrng_pkg::WORD_W];

	assign lag_word = diff[sbwrng_pkg::WORD_W-1:0] + (neg ? sbwrng_pkg::SWB_BASE : '0);
	assign out_word = lag_word + weyl_neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			borrow_q   <= 1'b1;
			weyl_neg_q <= sbwrng_pkg::WEYL_STEP;
		end else if (advance) begin
			if (op.gen) begin
				borrow_q   <= neg;
				weyl_neg_q <= weyl_neg_q + sbwrng_pkg::WEYL_STEP;
			end else if (op.restart) begin
				borrow_q   <= 1'b1;
				weyl_neg_q <= sbwrng_pkg::WEYL_STEP - seed;
			end
		end
	end

endmodule

// ===== rtl/subtract_borrow_weyl_rng.sv =====
// Top level of the lagged subtract-with-borrow / Weyl random word generator.
// Instantiates sbwrng_lag_ram and sbwrng_step; depends on sbwrng_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per cycle while in_ready
//   is high: kind 0 generates, kind 1 loads lag table entry 'index' (1..LONG_LAG)
//   from seed_value, kind 2 loads the Weyl word from seed_value and restarts borrow
//   and pointers. Kind 3 and out-of-range indices are accepted and do nothing.
//   Output channel (out_valid/out_ready) carries random_word, one per kind 0 word.
//   Throughput: one word per cycle when not stalled. Stage 0 issues both lag
//   reads from the pointer registers, stage 1 computes and writes back, with the
//   borrow loop closing in stage 1; a write on the same edge as a read of that
//   entry is forwarded. A generate word passes stage 1, then the output register.
//   Stalls: the output register plus the stage 1 slot absorb a stalled receiver;
//   in_ready drops only when both hold a generate word and out_ready is low.
//   Reset: lag table reads as zero (per-entry valid bits cleared at once), borrow
//   is one, the Weyl word zero, pointers LONG_LAG and SHORT_LAG. No clearing pass.

module subtract_borrow_weyl_rng_core #(
	parameter int LONG_LAG  = sbwrng_pkg::LONG_LAG_DEF,
	parameter int SHORT_LAG = sbwrng_pkg::SHORT_LAG_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sbwrng_pkg::KIND_W-1:0]  kind,
	input  logic [sbwrng_pkg::INDEX_W-1:0] index,
	input  logic [sbwrng_pkg::WORD_W-1:0]  seed_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sbwrng_pkg::WORD_W-1:0]  random_word
);

	localparam int PW          = $clog2(LONG_LAG + 1);
	localparam int AW          = $clog2(LONG_LAG);
	localparam int SHORT_START = (SHORT_LAG > LONG_LAG) ? LONG_LAG : SHORT_LAG;

	logic [PW-1:0] long_ptr_q, short_ptr_q;
	logic [PW-1:0] long_dec, short_dec;

	logic                          v_s1;
	sbwrng_pkg::op_t               op_s1;
	logic [AW-1:0]                 waddr_s1;
	logic [sbwrng_pkg::WORD_W-1:0] seed_s1;

	logic                          out_valid_q;
	logic [sbwrng_pkg::WORD_W-1:0] random_word_q;

	logic                          accept, s1_go, idx_ok;
	sbwrng_pkg::op_t               op_in;
	logic [sbwrng_pkg::WORD_W-1:0] seed_in;
	logic [sbwrng_pkg::INDEX_W-1:0] idx_m1;
	logic [PW-1:0]                 long_m1, short_m1;
	logic [sbwrng_pkg::WORD_W-1:0] short_word, long_word, lag_word, out_word;
	logic                          we;

	assign s1_go    = v_s1 && (!op_s1.gen || !out_valid_q || out_ready);
	assign in_ready = !v_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	assign idx_ok = (index != '0) && (index <= sbwrng_pkg::INDEX_W'(LONG_LAG));

	always_comb begin
		op_in         = '0;
		op_in.gen     = (kind == sbwrng_pkg::KIND_GEN);
		op_in.restart = (kind == sbwrng_pkg::KIND_WEYL);
		op_in.lag_wr  = (kind == sbwrng_pkg::KIND_LAG) && idx_ok;
	end

	// seeding word one forces bit 0 high, word two forces it low
	always_comb begin
		seed_in = seed_value;
		if (kind == sbwrng_pkg::KIND_LAG) begin
			if (index == sbwrng_pkg::INDEX_W'(1)) begin
				seed_in[0] = 1'b1;
			end else if (index == sbwrng_pkg::INDEX_W'(2)) begin
				seed_in[0] = 1'b0;
			end
		end
	end

	assign idx_m1   = index - sbwrng_pkg::INDEX_W'(1);
	assign long_m1  = long_ptr_q - PW'(1);
	assign short_m1 = short_ptr_q - PW'(1);
	assign long_dec  = (long_ptr_q == PW'(1)) ? PW'(LONG_LAG) : long_m1;
	assign short_dec = (short_ptr_q == PW'(1)) ? PW'(LONG_LAG) : short_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ptr_q  <= PW'(LONG_LAG);
			short_ptr_q <= PW'(SHORT_START);
		end else if (accept) begin
			if (op_in.gen) begin
				long_ptr_q  <= long_dec;
				short_ptr_q <= short_dec;
			end else if (op_in.restart) begin
				long_ptr_q  <= PW'(LONG_LAG);
				short_ptr_q <= PW'(SHORT_START);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			op_s1 <= '0;
		end else if (accept) begin
			v_s1  <= 1'b1;
			op_s1 <= op_in;
		end else if (s1_go) begin
			v_s1  <= 1'b0;
			op_s1 <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seed_s1  <= seed_in;
			waddr_s1 <= op_in.gen ? long_m1[AW-1:0] : idx_m1[AW-1:0];
		end
	end

	assign we = s1_go && (op_s1.gen || op_s1.lag_wr);

	sbwrng_lag_ram #(
		.DEPTH (LONG_LAG),
		.AW    (AW)
	) u_lag_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.raddr_a (short_m1[AW-1:0]),
		.raddr_b (long_m1[AW-1:0]),
		.rdata_a (short_word),
		.rdata_b (long_word),
		.we      (we),
		.waddr   (waddr_s1),
		.wdata   (op_s1.gen ? lag_word : seed_s1)
	);

	sbwrng_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (s1_go),
		.op         (op_s1),
		.seed       (seed_s1),
		.short_word (short_word),
		.long_word  (long_word),
		.lag_word   (lag_word),
		.out_word   (out_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && op_s1.gen) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && op_s1.gen) begin
			random_word_q <= out_word;
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

endmodule

// ===== rtl/sbwrng_props.sv =====
// Port-level assertions for subtract_borrow_weyl_rng_core and the bind that attaches them.
// Depends on sbwrng_pkg.

module sbwrng_props (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [sbwrng_pkg::KIND_W-1:0] kind,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [sbwrng_pkg::WORD_W-1:0] random_word
);

	// a result word stays put while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(random_word))
		else $error("output word changed while stalled");

	// every accepted generate word must be followed by a valid result
	a_gen_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == sbwrng_pkg::KIND_GEN) |-> ##2 out_valid)
		else $error("generate word produced no result");

	// a result appears only from an earlier accepted generate word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (kind == sbwrng_pkg::KIND_GEN), 2))
		else $error("result without a generate word");

	// input side blocks only behind a stalled full output
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

endmodule

bind subtract_borrow_weyl_rng_core sbwrng_props u_props (.*);
